// File: rtl/rdpc_pkg.sv
// shared types and constants of the row delta pixel coder
`default_nettype none

package rdpc_pkg;

  localparam int PIX_W      = 24;
  localparam int ROW_LEN_W  = 13;
  localparam int CFG_DATA_W = 13;
  localparam int CFG_IDX_W  = 2;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DIRECTION    = 2'd0,
    CFG_PIXEL_FORMAT = 2'd1,
    CFG_GRAY_MODE    = 2'd2,
    CFG_ROW_LENGTH   = 2'd3
  } cfg_idx_e;

  localparam logic DIR_ENCODE = 1'b0;
  localparam logic DIR_DECODE = 1'b1;
  localparam logic FMT_565    = 1'b0;
  localparam logic FMT_BYTES  = 1'b1;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_in;
    logic             frame_start;
  } pix_in_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_out;
    logic             row_end;
  } pix_out_t;

  // controls of the per-field add/subtract unit
  typedef struct packed {
    logic sub;
    logic pixel_format;
    logic gray_mode;
  } comb_ctrl_t;

endpackage

`default_nettype wire

// File: rtl/rdpc_combine.sv
// wrapping add or subtract of a pixel and its left neighbour, per field or on the gray part only
`default_nettype none

module rdpc_combine
  import rdpc_pkg::*;
(
  input  logic [PIX_W-1:0] a_i,
  input  logic [PIX_W-1:0] b_i,
  input  comb_ctrl_t       ctrl_i,
  output logic [PIX_W-1:0] res_o
);

  logic [15:0] w16;
  logic [4:0]  r5;
  logic [5:0]  g6;
  logic [4:0]  b5;
  logic [7:0]  y0;
  logic [7:0]  y1;
  logic [7:0]  y2;

  always_comb begin
    w16 = ctrl_i.sub ? (a_i[15:0] - b_i[15:0]) : (a_i[15:0] + b_i[15:0]);
    r5  = ctrl_i.sub ? (a_i[15:11] - b_i[15:11]) : (a_i[15:11] + b_i[15:11]);
    g6  = ctrl_i.sub ? (a_i[10:5] - b_i[10:5]) : (a_i[10:5] + b_i[10:5]);
    b5  = ctrl_i.sub ? (a_i[4:0] - b_i[4:0]) : (a_i[4:0] + b_i[4:0]);
    y0  = ctrl_i.sub ? (a_i[7:0] - b_i[7:0]) : (a_i[7:0] + b_i[7:0]);
    y1  = ctrl_i.sub ? (a_i[15:8] - b_i[15:8]) : (a_i[15:8] + b_i[15:8]);
    y2  = ctrl_i.sub ? (a_i[23:16] - b_i[23:16]) : (a_i[23:16] + b_i[23:16]);

    if (ctrl_i.pixel_format == FMT_565) begin
      // upper byte is always zero in 5-6-5
      if (ctrl_i.gray_mode) begin
        res_o = {8'h00, w16};
      end else begin
        res_o = {8'h00, r5, g6, b5};
      end
    end else begin
      if (ctrl_i.gray_mode) begin
        res_o = {a_i[23:8], y0};
      end else begin
        res_o = {y2, y1, y0};
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/row_delta_pixel_coder.sv
// top level of the row delta pixel coder: config, row state, output skid
`default_nettype none

// Horizontal left-neighbour DPCM over a raster pixel stream.
// in channel (in_valid_i/in_ready_o/in_data_i): one word per pixel, with
// frame_start marking the first pixel of an image. out channel carries one
// word per input word: the left difference (encode) or the rebuilt pixel
// (decode); the first pixel of each row passes unchanged, row_end flags the
// last pixel of a row.
// cfg channel: register index plus data, always ready; write only while idle.
// a word accepted into an empty or draining result register lands there,
// else in the skid register. one word per cycle while in_ready_o is high,
// set by the single add/subtract stage whose result feeds the left-pixel
// register. stall: a two-entry output (result register plus skid register)
// keeps the input open for one more word while the receiver holds off; with
// both full in_ready_o drops until the receiver takes a word.
// reset: encode, 5-6-5, per-field, row length 4096, column 0, left pixel 0,
// both output entries empty. no clearing pass is needed.

module row_delta_pixel_coder
  import rdpc_pkg::*;
#(
  parameter int MAX_ROW_LENGTH = 4096
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,

  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  pix_in_t               in_data_i,

  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output pix_out_t              out_data_o,

  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  // column counter just holds 0..MAX-1; length compare needs one more bit
  localparam int CntW = (MAX_ROW_LENGTH > 2) ? $clog2(MAX_ROW_LENGTH) : 1;
  localparam int LenW = (CntW + 1 > ROW_LEN_W) ? CntW + 1 : ROW_LEN_W;

  // configuration registers
  logic                 direction_q;
  logic                 pixel_format_q;
  logic                 gray_mode_q;
  logic [ROW_LEN_W-1:0] row_length_q;

  // row state
  logic [PIX_W-1:0] left_q, left_d;
  logic [CntW-1:0]  column_q, column_d;

  // output entries
  pix_out_t out_q, skid_q;
  logic     out_vld_q, skid_vld_q;

  logic in_fire, out_fire;
  logic [LenW-1:0] len_raw, len_eff, col_inc;
  logic [CntW-1:0] col_cur;
  logic [PIX_W-1:0] pix, comb_res;
  comb_ctrl_t ctrl;
  pix_out_t   res;
  logic       last;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !skid_vld_q;
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_fire    = out_vld_q && out_ready_i;
  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      direction_q    <= DIR_ENCODE;
      pixel_format_q <= FMT_565;
      gray_mode_q    <= 1'b0;
      row_length_q   <= ROW_LEN_W'(4096);
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_DIRECTION:    direction_q    <= cfg_data_i[0];
        CFG_PIXEL_FORMAT: pixel_format_q <= cfg_data_i[0];
        CFG_GRAY_MODE:    gray_mode_q    <= cfg_data_i[0];
        CFG_ROW_LENGTH:   row_length_q   <= cfg_data_i[ROW_LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // zero acts as one, oversize saturates
  always_comb begin
    len_raw = LenW'(row_length_q);
    if (row_length_q == '0) begin
      len_eff = LenW'(1);
    end else if (len_raw > LenW'(MAX_ROW_LENGTH)) begin
      len_eff = LenW'(MAX_ROW_LENGTH);
    end else begin
      len_eff = len_raw;
    end
  end

  always_comb begin
    col_cur = in_data_i.frame_start ? '0 : column_q;
    pix     = (pixel_format_q == FMT_565) ?
              {8'h00, in_data_i.pixel_in[15:0]} : in_data_i.pixel_in;
    ctrl.sub          = (direction_q == DIR_ENCODE);
    ctrl.pixel_format = pixel_format_q;
    ctrl.gray_mode    = gray_mode_q;
  end

  rdpc_combine u_combine (
    .a_i    (pix),
    .b_i    (left_q),
    .ctrl_i (ctrl),
    .res_o  (comb_res)
  );

  always_comb begin
    if (col_cur == '0) begin
      res.pixel_out = pix;
      left_d        = pix;
    end else if (direction_q == DIR_ENCODE) begin
      res.pixel_out = comb_res;
      left_d        = pix;
    end else begin
      // decode chains on the rebuilt pixel
      res.pixel_out = comb_res;
      left_d        = comb_res;
    end
    col_inc     = LenW'(col_cur) + LenW'(1);
    last        = (col_inc >= len_eff);
    column_d    = last ? '0 : col_inc[CntW-1:0];
    res.row_end = last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q   <= '0;
      column_q <= '0;
    end else if (in_fire) begin
      left_q   <= left_d;
      column_q <= column_d;
    end
  end

  // result register plus skid register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (skid_vld_q) begin
      if (out_fire) begin
        skid_vld_q <= 1'b0;
      end
    end else if (in_fire) begin
      if (!out_vld_q || out_fire) begin
        out_vld_q <= 1'b1;
      end else begin
        skid_vld_q <= 1'b1;
      end
    end else if (out_fire) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_vld_q) begin
      if (out_fire) begin
        out_q <= skid_q;
      end
    end else if (in_fire) begin
      if (!out_vld_q || out_fire) begin
        out_q <= res;
      end else begin
        skid_q <= res;
      end
    end
  end

`ifndef ASSERT_OFF
  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |-> out_vld_q)
    else $error("skid entry valid while result register empty");

  a_empty_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && !out_vld_q) |=> (out_vld_q && !skid_vld_q))
    else $error("word into empty output did not land in result register");

  a_row_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && last) |=> (column_q == '0))
    else $error("column not cleared after last pixel of row");

  a_col_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (LenW'(column_q) < LenW'(MAX_ROW_LENGTH)))
    else $error("column beyond maximum row length");
`endif

endmodule

`default_nettype wire

// File: dv/row_delta_pixel_coder_tb.sv
// testbench of the row delta pixel coder: random and directed pixel streams, scoreboard check
`timescale 1ns / 100ps

module row_delta_pixel_coder_tb;
  import rdpc_pkg::*;

  // row length cap handed to the block and used by the predictor
  localparam int ROW_CAP = 4096;
  // pixels in the random part of the run
  localparam int RANDOM_WORDS = 1000;
  // back-to-back pixels sent under an oversize row length
  localparam int OVERSIZE_WORDS = 64;

  // predicts the coded word for every accepted pixel and checks what comes out
  class coder_scoreboard;
    logic        dir_mode;
    logic        fmt_mode;
    logic        gray_on;
    logic [12:0] row_len;
    logic [23:0] left_pix;
    int          col;
    pix_out_t    coded_words[$];
    int          errors;
    int          checked;

    function new();
      dir_mode = DIR_ENCODE;
      fmt_mode = FMT_565;
      gray_on  = 1'b0;
      row_len  = 13'd4096;
      left_pix = '0;
      col      = 0;
      errors   = 0;
      checked  = 0;
    endfunction

    function void write_reg(cfg_idx_e idx, logic [12:0] data);
      case (idx)
        CFG_DIRECTION:    dir_mode = data[0];
        CFG_PIXEL_FORMAT: fmt_mode = data[0];
        CFG_GRAY_MODE:    gray_on  = data[0];
        CFG_ROW_LENGTH:   row_len  = data;
        default: ;
      endcase
    endfunction

    // wrap-around add or subtract, per field or on the gray part only
    function logic [23:0] add_sub(logic [23:0] a, logic [23:0] b, bit sub);
      logic [4:0]  r;
      logic [5:0]  g;
      logic [4:0]  bl;
      logic [15:0] w;
      logic [7:0]  lo;
      logic [23:0] res;
      if (fmt_mode == FMT_565) begin
        if (gray_on) begin
          w = sub ? a[15:0] - b[15:0] : a[15:0] + b[15:0];
          return {8'h00, w};
        end
        r  = sub ? a[15:11] - b[15:11] : a[15:11] + b[15:11];
        g  = sub ? a[10:5] - b[10:5] : a[10:5] + b[10:5];
        bl = sub ? a[4:0] - b[4:0] : a[4:0] + b[4:0];
        return {8'h00, r, g, bl};
      end
      if (gray_on) begin
        lo = sub ? a[7:0] - b[7:0] : a[7:0] + b[7:0];
        return {a[23:8], lo};
      end
      for (int i = 0; i < 3; i++) begin
        res[8*i +: 8] = sub ? a[8*i +: 8] - b[8*i +: 8] : a[8*i +: 8] + b[8*i +: 8];
      end
      return res;
    endfunction

    function void note_input(pix_in_t word);
      logic [23:0] pix;
      int          len;
      pix_out_t    want;
      len = (row_len == 0) ? 1 : ((row_len > ROW_CAP) ? ROW_CAP : int'(row_len));
      pix = word.pixel_in;
      if (word.frame_start) col = 0;
      if (fmt_mode == FMT_565) pix[23:16] = '0;
      if (col == 0) begin
        want.pixel_out = pix;
        left_pix = pix;
      end else if (dir_mode == DIR_ENCODE) begin
        want.pixel_out = add_sub(pix, left_pix, 1'b1);
        left_pix = pix;
      end else begin
        want.pixel_out = add_sub(pix, left_pix, 1'b0);
        left_pix = want.pixel_out;
      end
      want.row_end = (col + 1 >= len);
      col = want.row_end ? 0 : col + 1;
      coded_words.push_back(want);
    endfunction

    function void check_result(pix_out_t got);
      pix_out_t want;
      if (coded_words.size() == 0) begin
        $display("%0t: unexpected word, expected none actual %h", $time, got);
        errors++;
        return;
      end
      want = coded_words.pop_front();
      checked++;
      if (got.pixel_out !== want.pixel_out) begin
        $display("%0t: pixel_out expected %h actual %h", $time, want.pixel_out, got.pixel_out);
        errors++;
      end
      if (got.row_end !== want.row_end) begin
        $display("%0t: row_end expected %b actual %b", $time, want.row_end, got.row_end);
        errors++;
      end
    endfunction

    function int pending();
      return coded_words.size();
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_ready_o;
  pix_in_t               in_data_i;
  logic                  out_valid_o;
  logic                  out_ready_i;
  pix_out_t              out_data_o;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  coder_scoreboard sb;

  // when set, neither side inserts idle cycles
  bit steady;
  int words_sent;
  int setups;

  row_delta_pixel_coder #(
    .MAX_ROW_LENGTH(ROW_CAP)
  ) DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // hard stop in case the block hangs
  initial begin
    #10ms;
    $display("FAIL row_delta_pixel_coder");
    $finish;
  end

  // idle cycles before the next word on either side
  function int pick_gap();
    if (steady) return 0;
    return $urandom_range(0, 10);
  endfunction

  // pixels lean toward the all-zero and all-one corners to force wrap-around
  function logic [23:0] rand_pixel();
    case ($urandom_range(0, 7))
      0: return 24'h000000;
      1: return 24'hFFFFFF;
      2: return 24'($urandom_range(0, 3));
      3: return 24'hFFFFFF - 24'($urandom_range(0, 3));
      default: return 24'($urandom);
    endcase
  endfunction

  // one-bit registers get random junk above bit 0, which must be ignored
  function logic [12:0] flag_word(logic b);
    logic [11:0] junk;
    junk = 12'($urandom_range(0, 4095));
    return {junk, b};
  endfunction

  // called at a falling edge; returns at a falling edge with valid still high
  task automatic send_pixel(logic [23:0] pix, logic fs);
    pix_in_t word;
    int      gap;
    word.pixel_in    = pix;
    word.frame_start = fs;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= word;
    do @(posedge clk_i); while (!(in_valid_i && in_ready_o));
    sb.note_input(word);
    words_sent++;
    @(negedge clk_i);
  endtask

  // stop sending and wait until every coded word is back, then let the pipe settle
  task automatic quiesce();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic cfg_write(cfg_idx_e idx, logic [12:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!(cfg_valid_i && cfg_ready_o));
    sb.write_reg(idx, data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // block is idle before any register changes
  task automatic configure(logic dir, logic fmt, logic gray, logic [12:0] len);
    quiesce();
    cfg_write(CFG_DIRECTION, flag_word(dir));
    cfg_write(CFG_PIXEL_FORMAT, flag_word(fmt));
    cfg_write(CFG_GRAY_MODE, flag_word(gray));
    cfg_write(CFG_ROW_LENGTH, len);
    setups++;
  endtask

  // receiver: random stalls, each coded word checked against the oldest prediction
  initial begin
    int gap;
    wait (rst_ni === 1'b1);
    @(negedge clk_i);
    forever begin
      gap = pick_gap();
      if (gap != 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!(out_valid_o && out_ready_i));
      sb.check_result(out_data_o);
      @(negedge clk_i);
    end
  end

  initial begin
    int          n;
    int          guard;
    logic [12:0] len;
    sb          = new();
    steady      = 1'b0;
    words_sent  = 0;
    setups      = 0;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    out_ready_i = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = CFG_DIRECTION;
    cfg_data_i  = '0;
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset settings: encode, 5-6-5 per field, 4096-pixel rows
    // upper byte of the input must be dropped, frame start mid-row restarts the row
    send_pixel(24'hFFFFFF, 1'b1);
    send_pixel(24'h000000, 1'b0);
    send_pixel(24'h00FFFF, 1'b0);
    send_pixel(24'hA5A5A5, 1'b0);
    send_pixel(24'h000001, 1'b0);
    send_pixel(24'h00F81F, 1'b1);
    send_pixel(24'h0007E0, 1'b0);

    // row length zero acts as one: every word starts and ends its row
    configure(DIR_ENCODE, FMT_BYTES, 1'b1, 13'd0);
    send_pixel(24'hFFFFFF, 1'b0);
    send_pixel(24'h123456, 1'b0);
    send_pixel(24'h000000, 1'b1);

    // decode three-byte per field, two-pixel rows, low byte wraps on the add
    configure(DIR_DECODE, FMT_BYTES, 1'b0, 13'd2);
    send_pixel(24'hFFFFFF, 1'b1);
    send_pixel(24'h000001, 1'b0);
    send_pixel(24'h000000, 1'b0);
    send_pixel(24'hFFFFFF, 1'b0);

    // decode 5-6-5 gray over three-pixel rows, stopped mid-row
    configure(DIR_DECODE, FMT_565, 1'b1, 13'd3);
    send_pixel(24'hFFFFFF, 1'b1);
    send_pixel(24'h000001, 1'b0);
    send_pixel(24'h00FFFF, 1'b0);
    send_pixel(24'h008000, 1'b0);

    // row shrinks under the current column and the format changes mid-row
    configure(DIR_ENCODE, FMT_BYTES, 1'b0, 13'd1);
    send_pixel(24'h80FF01, 1'b0);
    send_pixel(24'h7F00FE, 1'b0);

    // oversize length saturates to the cap: no row end in a long back-to-back run
    configure(DIR_ENCODE, FMT_BYTES, 1'b0, 13'h1FFF);
    steady = 1'b1;
    for (int i = 0; i < OVERSIZE_WORDS; i++) send_pixel(rand_pixel(), i == 0);
    steady = 1'b0;

    // random settings, each held for a burst of words
    n = words_sent + RANDOM_WORDS;
    while (words_sent < n) begin
      case ($urandom_range(0, 9))
        0: len = 13'd0;
        1: len = 13'($urandom_range(ROW_CAP + 1, 8191));
        2: len = 13'($urandom_range(13, 300));
        default: len = 13'($urandom_range(1, 12));
      endcase
      configure(1'($urandom), 1'($urandom), 1'($urandom), len);
      steady = ($urandom_range(0, 3) == 0);
      guard = $urandom_range(20, 80);
      for (int i = 0; i < guard; i++) begin
        // now and then hold the sender until the output side has caught up
        if ($urandom_range(0, 59) == 0) quiesce();
        send_pixel(rand_pixel(), (i == 0 && $urandom_range(0, 1) == 1) ||
                                 $urandom_range(0, 39) == 0);
      end
      steady = 1'b0;
    end

    // drain with a limit; anything still owed is a failure
    in_valid_i <= 1'b0;
    guard = 0;
    while (sb.pending() != 0 && guard < 5000) begin
      @(negedge clk_i);
      guard++;
    end
    repeat (8) @(negedge clk_i);
    if (sb.pending() != 0) begin
      $display("%0t: %0d coded words never arrived", $time, sb.pending());
      sb.errors++;
    end

    $display("%0d pixels sent under %0d register settings, %0d coded words checked",
             words_sent, setups, sb.checked);
    $display("%0d mismatches", sb.errors);
    if (sb.errors == 0) begin
      $display("PASS row_delta_pixel_coder");
    end else begin
      $display("FAIL row_delta_pixel_coder");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/rdpc_pkg.sv
rtl/rdpc_combine.sv
rtl/row_delta_pixel_coder.sv
dv/row_delta_pixel_coder_tb.sv
